### design/lecs_pkg.sv
`timescale 1ns / 1ps

package lecs_pkg;

    // Image geometry
    localparam int IMAGE_WIDTH  = 80;
    localparam int IMAGE_HEIGHT = 60;
    localparam int FRAME_BYTES  = (IMAGE_WIDTH * IMAGE_HEIGHT + 7) / 8;
    localparam int BYTE_AW      = $clog2(FRAME_BYTES);
    localparam int BIT_AW       = $clog2(IMAGE_WIDTH * IMAGE_HEIGHT);

    // Field widths
    localparam int PIX_W       = 8;
    localparam int COL_W       = 7;
    localparam int ROW_W       = 6;
    localparam int ERR_W       = 13;
    localparam int ANG_W       = 11;
    localparam int OFS_W       = 11;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 11;
    localparam int OUT_TDATA_W = 56;

    // Derived geometry constants
    localparam logic [COL_W-1:0]  CENTER_COL      = COL_W'(IMAGE_WIDTH / 2);
    localparam logic [COL_W-1:0]  LAST_COL        = COL_W'(IMAGE_WIDTH - 1);
    localparam logic [ROW_W-1:0]  MAX_ROWS        = ROW_W'(IMAGE_HEIGHT);
    localparam logic [BIT_AW-1:0] BOTTOM_ROW_BASE = BIT_AW'((IMAGE_HEIGHT - 1) * IMAGE_WIDTH);
    localparam logic [BIT_AW-1:0] ROW_STRIDE      = BIT_AW'(IMAGE_WIDTH);
    localparam logic [BYTE_AW-1:0] LAST_BYTE      = BYTE_AW'(FRAME_BYTES - 1);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_TO_SCAN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ERROR_OFFSET  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NEUTRAL_ANGLE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER_LIMIT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER_LIMIT   = 3'd4;

    // Configuration reset values
    localparam logic [ROW_W-1:0] RST_ROWS_TO_SCAN  = 6'd30;
    localparam logic [OFS_W-1:0] RST_ERROR_OFFSET  = 11'd120;
    localparam logic [ANG_W-1:0] RST_NEUTRAL_ANGLE = 11'd800;
    localparam logic [ANG_W-1:0] RST_UPPER_LIMIT   = 11'd1150;
    localparam logic [ANG_W-1:0] RST_LOWER_LIMIT   = 11'd450;

    typedef struct packed {
        logic [ROW_W-1:0] rows_to_scan;
        logic [OFS_W-1:0] error_offset;
        logic [ANG_W-1:0] neutral_angle;
        logic [ANG_W-1:0] upper_angle_limit;
        logic [ANG_W-1:0] lower_angle_limit;
    } cfg_t;

    // Controller to datapath
    typedef struct packed {
        logic accept_en;
        logic scan_init;
        logic row_start;
        logic rd_en;
        logic l_eval;
        logic r_setup;
        logic r_eval;
        logic row_end;
        logic total_calc;
        logic emit;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic frame_done;
        logic left_at_border;
        logic right_at_border;
        logic l_done;
        logic r_done;
        logic last_row;
        logic out_free;
    } dp_sts_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_ROW_START,
        ST_L_READ,
        ST_L_EVAL,
        ST_R_SETUP,
        ST_R_READ,
        ST_R_EVAL,
        ST_ROW_END,
        ST_TOTAL,
        ST_EMIT
    } state_t;

endpackage

### design/lecs_ram.sv
`timescale 1ns / 1ps

module lecs_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 600
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### design/lecs_ctrl.sv
`timescale 1ns / 1ps

module lecs_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  lecs_pkg::dp_sts_t sts,
    output lecs_pkg::dp_cmd_t cmd
);

    lecs_pkg::state_t state_reg, state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lecs_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            lecs_pkg::ST_IDLE:
            begin
                cmd.accept_en = 1'b1;
                if (sts.frame_done)
                begin
                    state_next = lecs_pkg::ST_INIT;
                end
            end
            lecs_pkg::ST_INIT:
            begin
                cmd.scan_init = 1'b1;
                state_next    = lecs_pkg::ST_ROW_START;
            end
            lecs_pkg::ST_ROW_START:
            begin
                cmd.row_start = 1'b1;
                state_next    = lecs_pkg::ST_L_READ;
            end
            lecs_pkg::ST_L_READ:
            begin
                if (sts.left_at_border)
                begin
                    state_next = lecs_pkg::ST_R_SETUP;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = lecs_pkg::ST_L_EVAL;
                end
            end
            lecs_pkg::ST_L_EVAL:
            begin
                cmd.l_eval = 1'b1;
                state_next = sts.l_done ? lecs_pkg::ST_R_SETUP : lecs_pkg::ST_L_READ;
            end
            lecs_pkg::ST_R_SETUP:
            begin
                cmd.r_setup = 1'b1;
                state_next  = lecs_pkg::ST_R_READ;
            end
            lecs_pkg::ST_R_READ:
            begin
                if (sts.right_at_border)
                begin
                    state_next = lecs_pkg::ST_ROW_END;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = lecs_pkg::ST_R_EVAL;
                end
            end
            lecs_pkg::ST_R_EVAL:
            begin
                cmd.r_eval = 1'b1;
                state_next = sts.r_done ? lecs_pkg::ST_ROW_END : lecs_pkg::ST_R_READ;
            end
            lecs_pkg::ST_ROW_END:
            begin
                cmd.row_end = 1'b1;
                state_next  = lecs_pkg::ST_TOTAL;
            end
            lecs_pkg::ST_TOTAL:
            begin
                cmd.total_calc = 1'b1;
                state_next     = lecs_pkg::ST_EMIT;
            end
            lecs_pkg::ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = sts.last_row ? lecs_pkg::ST_IDLE : lecs_pkg::ST_ROW_START;
                end
            end
            default:
            begin
                state_next = lecs_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### design/lecs_dp.sv
`timescale 1ns / 1ps

module lecs_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  lecs_pkg::cfg_t                      cfg,
    input  lecs_pkg::dp_cmd_t                   cmd,
    output lecs_pkg::dp_sts_t                   sts,
    input  logic                                in_valid,
    input  logic [lecs_pkg::PIX_W-1:0]          in_pixel,
    input  logic                                in_frame_start,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [lecs_pkg::OUT_TDATA_W-1:0]    out_data,
    output logic                                out_last
);

    localparam int CW   = lecs_pkg::COL_W;
    localparam int RW   = lecs_pkg::ROW_W;
    localparam int EW   = lecs_pkg::ERR_W;
    localparam int AW   = lecs_pkg::ANG_W;
    localparam int OW   = lecs_pkg::OFS_W;
    localparam int BAW  = lecs_pkg::BYTE_AW;
    localparam int BIW  = lecs_pkg::BIT_AW;
    localparam int PW   = lecs_pkg::PIX_W;
    localparam int XW   = EW + 2;
    localparam int PADW = lecs_pkg::OUT_TDATA_W - (RW + 3 * CW + EW + AW);

    // Frame capture
    logic [BAW-1:0] byte_cnt_reg, byte_cnt_next;
    logic [BAW-1:0] wr_idx;
    logic           wr_en;
    logic           frame_done;

    // Scan state
    logic [RW-1:0]  row_reg, row_next;
    logic [RW-1:0]  rows_eff_reg, rows_eff_next;
    logic [BIW-1:0] base_reg, base_next;
    logic [CW-1:0]  prev_mid_reg, prev_mid_next;
    logic [CW-1:0]  srch_col_reg, srch_col_next;
    logic [CW-1:0]  left_reg, left_next;
    logic [CW-1:0]  right_reg, right_next;
    logic [CW-1:0]  mid_reg, mid_next;
    logic [EW-1:0]  esum_reg, esum_next;
    logic [EW-1:0]  total_reg, total_next;

    // Output register
    logic                                out_valid_reg, out_valid_next;
    logic [lecs_pkg::OUT_TDATA_W-1:0]    out_data_reg, out_data_next;
    logic                                out_last_reg, out_last_next;

    // Byte search
    logic [BIW-1:0] bit_addr;
    logic [BAW-1:0] rd_addr;
    logic [2:0]     offs;
    logic [PW-1:0]  rd_data;
    logic           l_found, r_found;
    logic [2:0]     l_pos, r_pos;
    logic           l_end, r_end;
    logic [CW-1:0]  r_rem;
    logic [CW:0]    edge_sum;
    logic           last_row;

    // Final error and angle
    logic signed [EW:0]   err_wide;
    logic [EW-1:0]        err_sat;
    logic signed [XW-1:0] ang_raw, ang_lo, ang_hi, ang_a, ang_b;
    logic [EW-1:0]        total_out;
    logic [AW-1:0]        angle_out;

    // Write side: frame_start restarts the byte count
    assign wr_idx     = in_frame_start ? '0 : byte_cnt_reg;
    assign wr_en      = cmd.accept_en & in_valid;
    assign frame_done = wr_en && (wr_idx == lecs_pkg::LAST_BYTE);

    always_comb
    begin
        byte_cnt_next = byte_cnt_reg;
        if (wr_en)
        begin
            byte_cnt_next = frame_done ? '0 : wr_idx + BAW'(1);
        end
    end

    // Read address of the pixel under search
    assign bit_addr = base_reg + BIW'(srch_col_reg);
    assign rd_addr  = BAW'(bit_addr[BIW-1:3]);
    assign offs     = bit_addr[2:0];

    lecs_ram #(
        .DATA_W (PW),
        .DEPTH  (lecs_pkg::FRAME_BYTES)
    ) u_frame_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_idx),
        .wr_data (in_pixel),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Left search: nearest black pixel at or left of the search column
    always_comb
    begin
        l_found = 1'b0;
        l_pos   = '0;
        for (int j = 0; j < 8; j++)
        begin
            if (rd_data[7-j] && (3'(j) <= offs) && (CW'(offs - 3'(j)) <= srch_col_reg))
            begin
                l_found = 1'b1;
                l_pos   = 3'(j);
            end
        end
    end
    assign l_end = (CW'(offs) >= srch_col_reg);

    // Right search: nearest black pixel at or right of the search column
    assign r_rem = lecs_pkg::LAST_COL - srch_col_reg;
    always_comb
    begin
        r_found = 1'b0;
        r_pos   = '0;
        for (int j = 7; j >= 0; j--)
        begin
            if (rd_data[7-j] && (3'(j) >= offs) && (CW'(3'(j) - offs) <= r_rem))
            begin
                r_found = 1'b1;
                r_pos   = 3'(j);
            end
        end
    end
    assign r_end = (CW'(3'd7 - offs) >= r_rem);

    assign edge_sum = {1'b0, left_reg} + {1'b0, right_reg};
    assign last_row = (row_reg == rows_eff_reg - RW'(1));

    // Corrected error, saturated to the field range
    assign err_wide = $signed({esum_reg[EW-1], esum_reg})
                    + $signed({{(EW + 1 - OW){cfg.error_offset[OW-1]}}, cfg.error_offset});
    always_comb
    begin
        err_sat = err_wide[EW-1:0];
        if (err_wide[EW] != err_wide[EW-1])
        begin
            err_sat = err_wide[EW] ? {1'b1, {(EW-1){1'b0}}} : {1'b0, {(EW-1){1'b1}}};
        end
    end

    // Steering angle, lower limit first so that crossed limits give the upper one
    assign ang_raw = $signed({{(XW - AW){1'b0}}, cfg.neutral_angle})
                   - $signed({{(XW - EW){total_reg[EW-1]}}, total_reg});
    assign ang_lo  = $signed({{(XW - AW){1'b0}}, cfg.lower_angle_limit});
    assign ang_hi  = $signed({{(XW - AW){1'b0}}, cfg.upper_angle_limit});
    assign ang_a   = (ang_raw < ang_lo) ? ang_lo : ang_raw;
    assign ang_b   = (ang_a > ang_hi) ? ang_hi : ang_a;

    assign total_out = last_row ? total_reg : '0;
    assign angle_out = last_row ? ang_b[AW-1:0] : '0;

    // Scan datapath updates
    always_comb
    begin
        row_next       = row_reg;
        rows_eff_next  = rows_eff_reg;
        base_next      = base_reg;
        prev_mid_next  = prev_mid_reg;
        srch_col_next  = srch_col_reg;
        left_next      = left_reg;
        right_next     = right_reg;
        mid_next       = mid_reg;
        esum_next      = esum_reg;
        total_next     = total_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.scan_init)
        begin
            row_next      = '0;
            base_next     = lecs_pkg::BOTTOM_ROW_BASE;
            prev_mid_next = lecs_pkg::CENTER_COL;
            esum_next     = '0;
            if (cfg.rows_to_scan == '0)
            begin
                rows_eff_next = RW'(1);
            end
            else if (cfg.rows_to_scan > lecs_pkg::MAX_ROWS)
            begin
                rows_eff_next = lecs_pkg::MAX_ROWS;
            end
            else
            begin
                rows_eff_next = cfg.rows_to_scan;
            end
        end

        if (cmd.row_start)
        begin
            left_next     = (prev_mid_reg == '0) ? '0 : prev_mid_reg - CW'(1);
            srch_col_next = prev_mid_reg - CW'(2);
            right_next    = (prev_mid_reg >= lecs_pkg::LAST_COL) ? lecs_pkg::LAST_COL
                                                                 : prev_mid_reg + CW'(1);
        end

        if (cmd.l_eval)
        begin
            if (l_found)
            begin
                left_next = srch_col_reg - CW'(offs - l_pos) + CW'(1);
            end
            else if (l_end)
            begin
                left_next = '0;
            end
            else
            begin
                srch_col_next = srch_col_reg - CW'(offs) - CW'(1);
            end
        end

        if (cmd.r_setup)
        begin
            srch_col_next = right_reg + CW'(1);
        end

        if (cmd.r_eval)
        begin
            if (r_found)
            begin
                right_next = srch_col_reg + CW'(r_pos - offs) - CW'(1);
            end
            else if (r_end)
            begin
                right_next = lecs_pkg::LAST_COL;
            end
            else
            begin
                srch_col_next = srch_col_reg + CW'(3'd7 - offs) + CW'(1);
            end
        end

        if (cmd.row_end)
        begin
            mid_next      = edge_sum[CW:1];
            prev_mid_next = edge_sum[CW:1];
            esum_next     = esum_reg + EW'(edge_sum[CW:1]) - EW'(lecs_pkg::CENTER_COL);
        end

        if (cmd.total_calc)
        begin
            total_next = err_sat;
        end

        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            out_last_next  = last_row;
            out_data_next  = {{PADW{1'b0}}, angle_out, total_out,
                              mid_reg, right_reg, left_reg, row_reg};
            row_next       = row_reg + RW'(1);
            base_next      = base_reg - lecs_pkg::ROW_STRIDE;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
            row_reg       <= '0;
            rows_eff_reg  <= RW'(1);
            prev_mid_reg  <= lecs_pkg::CENTER_COL;
            esum_reg      <= '0;
        end
        else
        begin
            byte_cnt_reg  <= byte_cnt_next;
            out_valid_reg <= out_valid_next;
            row_reg       <= row_next;
            rows_eff_reg  <= rows_eff_next;
            prev_mid_reg  <= prev_mid_next;
            esum_reg      <= esum_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        base_reg     <= base_next;
        srch_col_reg <= srch_col_next;
        left_reg     <= left_next;
        right_reg    <= right_next;
        mid_reg      <= mid_next;
        total_reg    <= total_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign sts.frame_done      = frame_done;
    assign sts.left_at_border  = (left_reg == '0);
    assign sts.right_at_border = (right_reg == lecs_pkg::LAST_COL);
    assign sts.l_done          = l_found | l_end;
    assign sts.r_done          = r_found | r_end;
    assign sts.last_row        = last_row;
    assign sts.out_free        = ~out_valid_reg | out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_last  = out_last_reg;

endmodule

### design/lane_edge_centerline_steer.sv
`timescale 1ns / 1ps

// Lane centerline tracker on a packed 1-bit frame (80 x 60, MSB = leftmost, 1 = black).
// s_axis carries the frame bytes; tuser high marks the first byte of a frame and
// restarts the byte count. The byte that completes the frame starts a scan of
// rows_to_scan rows (0 taken as 1, at most 60) upward from the bottom; m_axis then
// delivers one result per row, tlast high on the final row, which also carries total
// error and steering angle. cfg writes one register per transfer (index 0..4) and is
// always ready; write it only while no scan or result is pending.
// Throughput: s_axis takes one byte per cycle while no scan runs. The scan is then
// closed to input. Each row passes through the row start, left search, right setup,
// right search, row end, total and emit states; each edge search reads one frame-store
// byte per step (registered read) and reads nothing when it starts at the image border.
// When the receiver stalls, the held result waits in the output register and the
// scan pauses until it is taken. Reset loads the default configuration, clears the
// byte count and the output; frame memory content is not cleared.
module lane_edge_centerline_steer (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Pixel stream
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [7:0]                            s_axis_tdata,  // [7:0] pixel_byte
    input  logic                                  s_axis_tuser,  // [0] frame_start
    // Row results
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // [5:0] row_index, [12:6] left_bound, [19:13] right_bound, [26:20] midpoint,
    // [39:27] total_error, [50:40] steering_angle, [55:51] zero
    output logic [lecs_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    output logic                                  m_axis_tlast,  // last_row
    // Configuration writes
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [lecs_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [lecs_pkg::CFG_DATA_W-1:0]       cfg_data
);

    lecs_pkg::cfg_t    cfg_reg, cfg_next;
    lecs_pkg::dp_cmd_t cmd;
    lecs_pkg::dp_sts_t sts;

    assign cfg_ready = 1'b1;

    // Register file writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                lecs_pkg::CFG_ROWS_TO_SCAN:
                    cfg_next.rows_to_scan = cfg_data[lecs_pkg::ROW_W-1:0];
                lecs_pkg::CFG_ERROR_OFFSET:
                    cfg_next.error_offset = cfg_data[lecs_pkg::OFS_W-1:0];
                lecs_pkg::CFG_NEUTRAL_ANGLE:
                    cfg_next.neutral_angle = cfg_data[lecs_pkg::ANG_W-1:0];
                lecs_pkg::CFG_UPPER_LIMIT:
                    cfg_next.upper_angle_limit = cfg_data[lecs_pkg::ANG_W-1:0];
                lecs_pkg::CFG_LOWER_LIMIT:
                    cfg_next.lower_angle_limit = cfg_data[lecs_pkg::ANG_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rows_to_scan      <= lecs_pkg::RST_ROWS_TO_SCAN;
            cfg_reg.error_offset      <= lecs_pkg::RST_ERROR_OFFSET;
            cfg_reg.neutral_angle     <= lecs_pkg::RST_NEUTRAL_ANGLE;
            cfg_reg.upper_angle_limit <= lecs_pkg::RST_UPPER_LIMIT;
            cfg_reg.lower_angle_limit <= lecs_pkg::RST_LOWER_LIMIT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    lecs_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    lecs_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .cmd            (cmd),
        .sts            (sts),
        .in_valid       (s_axis_tvalid),
        .in_pixel       (s_axis_tdata),
        .in_frame_start (s_axis_tuser),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .out_data       (m_axis_tdata),
        .out_last       (m_axis_tlast)
    );

    assign s_axis_tready = cmd.accept_en;

    // Midpoint always lies between the left and right edges
    property p_mid_between_edges;
        @(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[12:6] <= m_axis_tdata[26:20])
                       && (m_axis_tdata[26:20] <= m_axis_tdata[19:13]);
    endproperty
    a_mid_between_edges: assert property (p_mid_between_edges)
        else $error("midpoint outside lane edges");

    // Error and angle fields are zero except on the last row
    property p_summary_only_last;
        @(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tdata[50:27] == '0);
    endproperty
    a_summary_only_last: assert property (p_summary_only_last)
        else $error("summary fields set on a non-final row");

    // Input closes once a frame is complete
    property p_closed_during_scan;
        @(posedge clk) disable iff (!rst_n)
        sts.frame_done |=> !s_axis_tready;
    endproperty
    a_closed_during_scan: assert property (p_closed_during_scan)
        else $error("pixel input open during scan");

    // Final angle respects the limits when they are ordered
    property p_angle_in_limits;
        @(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast
         && (cfg_reg.lower_angle_limit <= cfg_reg.upper_angle_limit))
        |-> (m_axis_tdata[50:40] >= cfg_reg.lower_angle_limit)
         && (m_axis_tdata[50:40] <= cfg_reg.upper_angle_limit);
    endproperty
    a_angle_in_limits: assert property (p_angle_in_limits)
        else $error("steering angle outside limits");

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

// One expected row result
typedef struct {
    bit [lecs_pkg::ROW_W-1:0] row_index;
    bit [lecs_pkg::COL_W-1:0] left_bound;
    bit [lecs_pkg::COL_W-1:0] right_bound;
    bit [lecs_pkg::COL_W-1:0] midpoint;
    bit                       last_row;
    bit [lecs_pkg::ERR_W-1:0] total_error;
    bit [lecs_pkg::ANG_W-1:0] steering_angle;
} row_result_t;

// Frame store mirror, register copy and the queue of rows still to arrive
class lane_scoreboard;
    bit [7:0]                        image [lecs_pkg::FRAME_BYTES];
    int                              bytes_in;
    bit [lecs_pkg::ROW_W-1:0]        rows_cfg;
    bit signed [lecs_pkg::OFS_W-1:0] offset_cfg;
    bit [lecs_pkg::ANG_W-1:0]        center_cfg;
    bit [lecs_pkg::ANG_W-1:0]        upper_cfg;
    bit [lecs_pkg::ANG_W-1:0]        lower_cfg;
    row_result_t                     rows_due [$];
    int                              errors;

    function new();
        bytes_in   = 0;
        rows_cfg   = lecs_pkg::RST_ROWS_TO_SCAN;
        offset_cfg = lecs_pkg::RST_ERROR_OFFSET;
        center_cfg = lecs_pkg::RST_NEUTRAL_ANGLE;
        upper_cfg  = lecs_pkg::RST_UPPER_LIMIT;
        lower_cfg  = lecs_pkg::RST_LOWER_LIMIT;
        errors     = 0;
    endfunction

    function void write_reg(bit [lecs_pkg::CFG_IDX_W-1:0] idx,
                            bit [lecs_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            lecs_pkg::CFG_ROWS_TO_SCAN:  rows_cfg   = data[lecs_pkg::ROW_W-1:0];
            lecs_pkg::CFG_ERROR_OFFSET:  offset_cfg = data[lecs_pkg::OFS_W-1:0];
            lecs_pkg::CFG_NEUTRAL_ANGLE: center_cfg = data[lecs_pkg::ANG_W-1:0];
            lecs_pkg::CFG_UPPER_LIMIT:   upper_cfg  = data[lecs_pkg::ANG_W-1:0];
            lecs_pkg::CFG_LOWER_LIMIT:   lower_cfg  = data[lecs_pkg::ANG_W-1:0];
            default: ;
        endcase
    endfunction

    // row counted from the bottom of the image
    function bit pixel_black(int col, int row);
        int b;
        b = (lecs_pkg::IMAGE_HEIGHT - 1 - row) * lecs_pkg::IMAGE_WIDTH + col;
        return image[b / 8][7 - (b % 8)];
    endfunction

    // Edge search over the stored frame, one result per row
    function void scan_rows();
        int rows, s, left, right, mid, prev, sum, total, angle;
        row_result_t r;
        rows = rows_cfg;
        if (rows == 0)
            rows = 1;
        if (rows > lecs_pkg::IMAGE_HEIGHT)
            rows = lecs_pkg::IMAGE_HEIGHT;
        prev = lecs_pkg::IMAGE_WIDTH / 2;
        sum  = 0;
        for (int i = 0; i < rows; i++)
        begin
            s     = prev;
            left  = (s > 0) ? s - 1 : 0;
            right = (s + 1 < lecs_pkg::IMAGE_WIDTH) ? s + 1 : lecs_pkg::IMAGE_WIDTH - 1;
            while (left > 0 && !pixel_black(left - 1, i))
                left--;
            while (right < lecs_pkg::IMAGE_WIDTH - 1 && !pixel_black(right + 1, i))
                right++;
            mid  = (left + right) / 2;
            prev = mid;
            sum += mid - lecs_pkg::IMAGE_WIDTH / 2;
            r.row_index      = lecs_pkg::ROW_W'(i);
            r.left_bound     = lecs_pkg::COL_W'(left);
            r.right_bound    = lecs_pkg::COL_W'(right);
            r.midpoint       = lecs_pkg::COL_W'(mid);
            r.last_row       = 1'b0;
            r.total_error    = '0;
            r.steering_angle = '0;
            if (i == rows - 1)
            begin
                total = sum + offset_cfg;
                if (total > 4095)
                    total = 4095;
                if (total < -4096)
                    total = -4096;
                angle = int'(center_cfg) - total;
                if (angle < int'(lower_cfg))
                    angle = lower_cfg;
                if (angle > int'(upper_cfg))
                    angle = upper_cfg;
                r.last_row       = 1'b1;
                r.total_error    = lecs_pkg::ERR_W'(total);
                r.steering_angle = lecs_pkg::ANG_W'(angle);
            end
            rows_due.push_back(r);
        end
    endfunction

    function void note_byte(bit [7:0] pix, bit start);
        if (start)
            bytes_in = 0;
        image[bytes_in] = pix;
        bytes_in++;
        if (bytes_in == lecs_pkg::FRAME_BYTES)
        begin
            bytes_in = 0;
            scan_rows();
        end
    endfunction

    function void compare_field(string name, int want, int got);
        if (want != got)
        begin
            errors++;
            $error("%s: expected %0d, actual %0d", name, want, got);
        end
    endfunction

    // tdata: [5:0] row, [12:6] left, [19:13] right, [26:20] mid,
    // [39:27] total error, [50:40] angle
    function void check_row(bit [lecs_pkg::OUT_TDATA_W-1:0] data, bit last);
        row_result_t want;
        if (rows_due.size() == 0)
        begin
            errors++;
            $error("row result transfer with no result pending");
            return;
        end
        want = rows_due.pop_front();
        compare_field("row_index", want.row_index, data[5:0]);
        compare_field("left_bound", want.left_bound, data[12:6]);
        compare_field("right_bound", want.right_bound, data[19:13]);
        compare_field("midpoint", want.midpoint, data[26:20]);
        compare_field("last_row", want.last_row, last);
        compare_field("total_error", int'($signed(want.total_error)),
                      int'($signed(data[39:27])));
        compare_field("steering_angle", want.steering_angle, data[50:40]);
    endfunction

    function int pending();
        return rows_due.size();
    endfunction
endclass

module testbench;

    localparam logic [lecs_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

    typedef enum {FILL_WHITE, FILL_BLACK, FILL_NOISE, FILL_LANE} fill_mode_t;

    logic                             clk = 1'b0;
    logic                             rst_n;
    logic                             s_axis_tvalid;
    logic                             s_axis_tready;
    logic [7:0]                       s_axis_tdata;   // [7:0] pixel_byte
    logic                             s_axis_tuser;   // [0] frame_start
    logic                             m_axis_tvalid;
    logic                             m_axis_tready;
    logic [lecs_pkg::OUT_TDATA_W-1:0] m_axis_tdata;   // row, left, right, mid, error, angle
    logic                             m_axis_tlast;   // last_row
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [lecs_pkg::CFG_IDX_W-1:0]   cfg_index;
    logic [lecs_pkg::CFG_DATA_W-1:0]  cfg_data;

    lane_scoreboard sb = new();
    bit             no_idle = 1'b0;
    bit [7:0]       frame_buf [lecs_pkg::FRAME_BYTES];

    always #2 clk = ~clk;

    lane_edge_centerline_steer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Paint one black pixel, y counted from the top; off-image columns are dropped
    function void paint(int y, int col);
        int b;
        if (col >= 0 && col < lecs_pkg::IMAGE_WIDTH)
        begin
            b = y * lecs_pkg::IMAGE_WIDTH + col;
            frame_buf[b / 8][7 - (b % 8)] = 1'b1;
        end
    endfunction

    function void fill_frame(fill_mode_t mode);
        int c, w, t;
        for (int i = 0; i < lecs_pkg::FRAME_BYTES; i++)
        begin
            case (mode)
                FILL_BLACK: frame_buf[i] = 8'hFF;
                FILL_NOISE: frame_buf[i] = 8'($urandom_range(0, 255));
                default:    frame_buf[i] = 8'h00;
            endcase
        end
        if (mode == FILL_LANE)
        begin
            // two drifting lines of random width with gaps and speckle
            c = $urandom_range(25, 55);
            w = $urandom_range(4, 30);
            for (int y = lecs_pkg::IMAGE_HEIGHT - 1; y >= 0; y--)
            begin
                c = c + int'($urandom_range(0, 4)) - 2;
                if (c < 5)
                    c = 5;
                if (c > 74)
                    c = 74;
                w = w + int'($urandom_range(0, 2)) - 1;
                if (w < 2)
                    w = 2;
                if (w > 40)
                    w = 40;
                t = $urandom_range(1, 3);
                if ($urandom_range(0, 9) != 0)
                    for (int k = 0; k < t; k++)
                        paint(y, c - w - k);
                if ($urandom_range(0, 9) != 0)
                    for (int k = 0; k < t; k++)
                        paint(y, c + w + k);
                if ($urandom_range(0, 5) == 0)
                    paint(y, $urandom_range(0, lecs_pkg::IMAGE_WIDTH - 1));
            end
        end
    endfunction

    // Called and returns at a falling edge; tvalid is left high
    task automatic send_byte(bit [7:0] pix, bit start);
        while (!no_idle && $urandom_range(0, 99) < 17)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pix;
        s_axis_tuser  <= start;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_byte(pix, start);
        @(negedge clk);
    endtask

    // Send the first count bytes of frame_buf; glitch adds one restart mid-run
    task automatic send_frame(int count, bit first_start, bit glitch);
        int k;
        k = glitch ? int'($urandom_range(1, count - 1)) : -1;
        for (int i = 0; i < count; i++)
            send_byte(frame_buf[i], (i == 0 && first_start) || i == k);
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic write_reg(logic [lecs_pkg::CFG_IDX_W-1:0] idx,
                             logic [lecs_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Hold off until every pending row has arrived and the block has settled
    task automatic wait_drained();
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    // Receiver: random backpressure
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 17);
        end
    end

    // Row result check on every output transfer
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_row(m_axis_tdata, m_axis_tlast);
    end

    // Main stimulus
    initial
    begin
        int lo_ang, hi_ang, roll;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        rst_n         = 1'b0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset configuration: empty road and solid black frames
        fill_frame(FILL_WHITE);
        send_frame(lecs_pkg::FRAME_BYTES, 1'b1, 1'b0);
        fill_frame(FILL_BLACK);
        send_frame(lecs_pkg::FRAME_BYTES, 1'b1, 1'b0);

        // Aborted run, then a restart with frame_start
        fill_frame(FILL_NOISE);
        send_frame(250, 1'b1, 1'b0);
        fill_frame(FILL_LANE);
        send_frame(lecs_pkg::FRAME_BYTES, 1'b1, 1'b0);

        // Back-to-back frame with no frame_start: byte count wraps on its own
        fill_frame(FILL_LANE);
        send_frame(lecs_pkg::FRAME_BYTES, 1'b0, 1'b0);
        wait_drained();

        // Full height, largest offset and angles
        write_reg(lecs_pkg::CFG_ROWS_TO_SCAN, 11'd60);
        write_reg(lecs_pkg::CFG_ERROR_OFFSET, 11'h3FF);
        write_reg(lecs_pkg::CFG_NEUTRAL_ANGLE, 11'h7FF);
        write_reg(lecs_pkg::CFG_UPPER_LIMIT, 11'h7FF);
        write_reg(lecs_pkg::CFG_LOWER_LIMIT, 11'd0);
        fill_frame(FILL_LANE);
        send_frame(lecs_pkg::FRAME_BYTES, 1'b1, 1'b0);
        wait_drained();

        // Zero rows means one row; most negative offset, zero center
        write_reg(lecs_pkg::CFG_ROWS_TO_SCAN, 11'd0);
        write_reg(lecs_pkg::CFG_ERROR_OFFSET, 11'h400);
        write_reg(lecs_pkg::CFG_NEUTRAL_ANGLE, 11'd0);
        write_reg(lecs_pkg::CFG_UPPER_LIMIT, 11'd1800);
        fill_frame(FILL_LANE);
        send_frame(lecs_pkg::FRAME_BYTES, 1'b1, 1'b0);
        wait_drained();

        // Row count beyond the image, crossed limits, write to an unused index;
        // no idling on either side for this frame
        write_reg(lecs_pkg::CFG_ROWS_TO_SCAN, 11'd63);
        write_reg(lecs_pkg::CFG_ERROR_OFFSET, 11'd0);
        write_reg(lecs_pkg::CFG_NEUTRAL_ANGLE, 11'd800);
        write_reg(lecs_pkg::CFG_UPPER_LIMIT, 11'd300);
        write_reg(lecs_pkg::CFG_LOWER_LIMIT, 11'd1500);
        write_reg(CFG_UNUSED_IDX, 11'h7FF);
        no_idle = 1'b1;
        fill_frame(FILL_LANE);
        send_frame(lecs_pkg::FRAME_BYTES, 1'b1, 1'b0);
        wait_drained();
        no_idle = 1'b0;

        // Random frames, mostly well-formed lanes, some aborted or restarted
        for (int f = 0; f < 8; f++)
        begin
            if (f == 0 || $urandom_range(0, 2) == 0)
            begin
                wait_drained();
                lo_ang = $urandom_range(0, 1800);
                hi_ang = $urandom_range(0, 1800);
                if ((lo_ang > hi_ang) != ($urandom_range(0, 4) == 0))
                begin
                    roll   = lo_ang;
                    lo_ang = hi_ang;
                    hi_ang = roll;
                end
                write_reg(lecs_pkg::CFG_ROWS_TO_SCAN, 11'($urandom_range(0, 63)));
                write_reg(lecs_pkg::CFG_ERROR_OFFSET, 11'($urandom_range(0, 2047)));
                write_reg(lecs_pkg::CFG_NEUTRAL_ANGLE, 11'($urandom_range(0, 2047)));
                write_reg(lecs_pkg::CFG_UPPER_LIMIT, 11'(hi_ang));
                write_reg(lecs_pkg::CFG_LOWER_LIMIT, 11'(lo_ang));
            end
            roll = $urandom_range(0, 9);
            fill_frame(roll < 7 ? FILL_LANE : roll == 7 ? FILL_NOISE :
                       roll == 8 ? FILL_WHITE : FILL_BLACK);
            roll = $urandom_range(0, 9);
            if (roll == 0)
            begin
                send_frame($urandom_range(1, lecs_pkg::FRAME_BYTES - 1), 1'b1, 1'b0);
                fill_frame(FILL_LANE);
                send_frame(lecs_pkg::FRAME_BYTES, 1'b1, 1'b0);
            end
            else if (roll == 1)
                send_frame(lecs_pkg::FRAME_BYTES, 1'b1, 1'b1);
            else
                send_frame(lecs_pkg::FRAME_BYTES, 1'b1, 1'b0);
        end

        wait_drained();
        if (sb.errors == 0)
            $display("lane_edge_centerline_steer: match");
        else
            $display("lane_edge_centerline_steer: mismatch");
        $finish;
    end

    // Watchdog
    initial
    begin
        #4000000;
        $display("lane_edge_centerline_steer: mismatch");
        $finish;
    end

endmodule
